// ===== design/link_self_cure_fsm_with_blocklist_assert.svh =====
// Assertion macros for the link self-cure block and its port checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef LINK_SELF_CURE_FSM_WITH_BLOCKLIST_ASSERT_SVH
`define LINK_SELF_CURE_FSM_WITH_BLOCKLIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lscb_pkg.sv =====
// Shared types and codes for the link self-cure detector with peer blocklist.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package lscb_pkg;

  localparam int ADDR_W  = 48;
  localparam int CMD_W   = 3;
  localparam int DET_W   = 3;
  localparam int RETRY_W = 4;
  localparam int PROTO_W = 2;
  localparam int BCNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CMD_W-1:0] CMD_ASSOC     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DHCP_TX   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DHCP_RX   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EAPOL_RX  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd5;

  localparam logic [DET_W-1:0] DET_INIT         = 3'd0;
  localparam logic [DET_W-1:0] DET_ASSOC        = 3'd1;
  localparam logic [DET_W-1:0] DET_HT_DHCP      = 3'd2;
  localparam logic [DET_W-1:0] DET_CLOSE_HT     = 3'd3;
  localparam logic [DET_W-1:0] DET_LEGACY_ASSOC = 3'd4;
  localparam logic [DET_W-1:0] DET_LEGACY_DHCP  = 3'd5;

  localparam logic [PROTO_W-1:0] PROTO_LEGACY = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_HT     = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT    = 1'd1;

  localparam logic [RETRY_W-1:0] RETRY_MAX         = 4'd15;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 4'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  peer_addr;
    logic               sta_is_legacy;
    logic [PROTO_W-1:0] protocol_class;
    logic               band_is_2g;
    logic               peer_is_special_ap;
  } in_item_t;

  typedef struct packed {
    logic               blocked_hit;
    logic               entry_added;
    logic [DET_W-1:0]   detector_state;
    logic [RETRY_W-1:0] retry_count;
    logic [BCNT_W-1:0]  blocklist_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/link_self_cure_fsm_with_blocklist.sv =====
// Link self-cure detector with peer blocklist; depends on lscb_pkg.
// A request is captured while idle, evaluated in SQ_EVAL and, when an add or a lookup needs
// it, checked in SQ_SCAN, where the blocklist is scanned one entry per cycle through the
// single-port list memory (a match ends it early); its result is registered in SQ_FIN.
// The block takes one request at a time and is busy until that request's result is shown;
// busy drops in the cycle the result is shown. Reset (rst, synchronous): detector, counters
// and list count cleared, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module link_self_cure_fsm_with_blocklist #(
  parameter int BLOCKLIST_DEPTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  lscb_pkg::in_item_t                    item,
  output logic                                  done,
  output lscb_pkg::result_t                     result,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [lscb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [lscb_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import lscb_pkg::*;

  localparam int CW = $clog2(BLOCKLIST_DEPTH + 1);
  localparam int IW = (BLOCKLIST_DEPTH > 1) ? $clog2(BLOCKLIST_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(BLOCKLIST_DEPTH);

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_EVAL = 2'd1;
  localparam logic [1:0] SQ_SCAN = 2'd2;
  localparam logic [1:0] SQ_FIN  = 2'd3;

  logic [1:0]         seq;
  logic               feature_enable;
  logic [RETRY_W-1:0] dhcp_retry_limit;
  logic [DET_W-1:0]   fsm_state;
  logic [RETRY_W-1:0] dhcp_count;
  logic [ADDR_W-1:0]  assoc_peer;
  logic [ADDR_W-1:0]  suspect_peer;
  logic [CW-1:0]      block_count;

  in_item_t           req;
  logic               is_add;
  logic               is_lookup;
  logic               direct_hit;
  logic               found;
  logic [CW-1:0]      scan_idx;
  logic               rd_pending;
  logic [ADDR_W-1:0]  rd_data;

  logic [ADDR_W-1:0]  blocklist [BLOCKLIST_DEPTH];

  // Event handling, evaluated on the captured request.
  logic [DET_W-1:0]   st_next;
  logic [RETRY_W-1:0] dc_next;
  logic [ADDR_W-1:0]  ap_next;
  logic [ADDR_W-1:0]  sp_next;
  logic               add_next;
  logic [RETRY_W-1:0] dc_inc;
  logic               sp_match;
  logic               event_on;
  logic               lookup_direct;
  logic               add_ok;
  logic [CW-1:0]      count_after;

  assign busy      = (seq != SQ_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    st_next  = fsm_state;
    dc_next  = dhcp_count;
    ap_next  = assoc_peer;
    sp_next  = suspect_peer;
    add_next = 1'b0;
    // An event for a different peer starts a fresh check.
    if (req.peer_addr != assoc_peer) begin
      st_next = DET_INIT;
      dc_next = '0;
      ap_next = '0;
      sp_next = '0;
    end
    sp_match = (sp_next == req.peer_addr);
    dc_inc   = (dc_next != RETRY_MAX) ? dc_next + RETRY_W'(1) : dc_next;
    case (st_next)
      DET_INIT: begin
        if (req.command == CMD_ASSOC) begin
          if (req.protocol_class == PROTO_HT) begin
            ap_next = req.peer_addr;
            st_next = DET_ASSOC;
            dc_next = '0;
            if (req.band_is_2g && req.peer_is_special_ap) begin
              sp_next = req.peer_addr;
            end
          end else begin
            st_next = DET_INIT;
            dc_next = '0;
            ap_next = '0;
            sp_next = '0;
          end
        end
      end
      DET_ASSOC: begin
        if (req.command == CMD_DHCP_TX) begin
          dc_next = dc_inc;
          st_next = DET_HT_DHCP;
        end else if (req.command == CMD_EAPOL_RX) begin
          if (sp_match) begin
            sp_next = '0;
          end
        end else if (req.command == CMD_ASSOC) begin
          if (sp_match) begin
            st_next = DET_LEGACY_ASSOC;
          end
        end
      end
      DET_HT_DHCP: begin
        if (req.command == CMD_DHCP_TX) begin
          dc_next = dc_inc;
          if (dc_inc > dhcp_retry_limit) begin
            st_next = DET_CLOSE_HT;
            sp_next = req.peer_addr;
          end
        end else if (req.command == CMD_DHCP_RX) begin
          st_next = DET_INIT;
          dc_next = '0;
          ap_next = '0;
          sp_next = '0;
        end
      end
      DET_CLOSE_HT: begin
        if (req.command == CMD_ASSOC) begin
          if (req.protocol_class == PROTO_LEGACY && sp_match) begin
            st_next = DET_LEGACY_ASSOC;
            dc_next = '0;
          end else begin
            st_next = DET_INIT;
            dc_next = '0;
            ap_next = '0;
            sp_next = '0;
          end
        end else if (req.command == CMD_DHCP_RX) begin
          st_next = DET_INIT;
          dc_next = '0;
          ap_next = '0;
          sp_next = '0;
        end
      end
      DET_LEGACY_ASSOC: begin
        if (req.command == CMD_DHCP_TX) begin
          st_next = DET_LEGACY_DHCP;
          dc_next = dc_inc;
        end else if (req.command == CMD_EAPOL_RX) begin
          if (req.band_is_2g && req.peer_is_special_ap && sp_match) begin
            add_next = 1'b1;
            st_next  = DET_INIT;
            dc_next  = '0;
            ap_next  = '0;
            sp_next  = '0;
          end
        end else if (req.command == CMD_ASSOC) begin
          if (sp_match) begin
            st_next = DET_INIT;
            dc_next = '0;
            ap_next = '0;
            sp_next = '0;
          end
        end
      end
      DET_LEGACY_DHCP: begin
        if (req.command == CMD_DHCP_TX) begin
          dc_next = dc_inc;
          if (dc_inc > dhcp_retry_limit) begin
            st_next = DET_INIT;
            dc_next = '0;
            ap_next = '0;
            sp_next = '0;
          end
        end else if (req.command == CMD_DHCP_RX) begin
          if (sp_match) begin
            add_next = 1'b1;
            st_next  = DET_INIT;
            dc_next  = '0;
            ap_next  = '0;
            sp_next  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    event_on = 1'b0;
    if (req.command inside {[CMD_ASSOC:CMD_EAPOL_RX]}) begin
      event_on = req.sta_is_legacy && feature_enable;
    end
  end

  assign lookup_direct = (suspect_peer == req.peer_addr) &&
                         (fsm_state == DET_CLOSE_HT || req.peer_is_special_ap);
  assign add_ok        = is_add && !found;
  assign count_after   = add_ok ? block_count + CW'(1) : block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq              <= SQ_IDLE;
      feature_enable   <= 1'b1;
      dhcp_retry_limit <= RETRY_LIMIT_RESET;
      fsm_state        <= DET_INIT;
      dhcp_count       <= '0;
      assoc_peer       <= '0;
      suspect_peer     <= '0;
      block_count      <= '0;
      done             <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FEATURE_ENABLE: feature_enable   <= cfg_data[0];
          REG_RETRY_LIMIT:    dhcp_retry_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      case (seq)
        SQ_IDLE: begin
          if (start) begin
            seq <= SQ_EVAL;
          end
        end
        SQ_EVAL: begin
          seq <= SQ_FIN;
          if (event_on) begin
            fsm_state    <= st_next;
            dhcp_count   <= dc_next;
            assoc_peer   <= ap_next;
            suspect_peer <= sp_next;
            if (add_next) begin
              seq <= SQ_SCAN;
              // A full list is wiped before it takes the new entry.
              if (block_count >= DEPTH_C) begin
                block_count <= '0;
              end
            end
          end else if (req.command == CMD_LOOKUP) begin
            if (feature_enable && !lookup_direct) begin
              seq <= SQ_SCAN;
            end
          end else if (req.command == CMD_CLEAR_ALL) begin
            fsm_state    <= DET_INIT;
            dhcp_count   <= '0;
            assoc_peer   <= '0;
            suspect_peer <= '0;
            block_count  <= '0;
          end
        end
        SQ_SCAN: begin
          if ((rd_pending && rd_data == req.peer_addr) ||
              (!rd_pending && scan_idx >= block_count)) begin
            seq <= SQ_FIN;
          end
        end
        SQ_FIN: begin
          block_count <= count_after;
          done        <= 1'b1;
          seq         <= SQ_IDLE;
        end
        default: seq <= SQ_IDLE;
      endcase
    end
  end

  // Request capture, scan bookkeeping and the result register.
  always_ff @(posedge clk) begin
    case (seq)
      SQ_IDLE: begin
        req <= item;
      end
      SQ_EVAL: begin
        is_add     <= event_on && add_next;
        is_lookup  <= (req.command == CMD_LOOKUP);
        direct_hit <= (req.command == CMD_LOOKUP) && feature_enable && lookup_direct;
        found      <= 1'b0;
        scan_idx   <= '0;
        rd_pending <= 1'b0;
      end
      SQ_SCAN: begin
        if (rd_pending && rd_data == req.peer_addr) begin
          found <= 1'b1;
        end
        if (scan_idx < block_count) begin
          scan_idx   <= scan_idx + CW'(1);
          rd_pending <= 1'b1;
        end else begin
          rd_pending <= 1'b0;
        end
      end
      SQ_FIN: begin
        result.blocked_hit     <= direct_hit || (is_lookup && found);
        result.entry_added     <= add_ok;
        result.detector_state  <= fsm_state;
        result.retry_count     <= dhcp_count;
        result.blocklist_count <= BCNT_W'(count_after);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= blocklist[scan_idx[IW-1:0]];
    if (seq == SQ_FIN && add_ok) begin
      blocklist[block_count[IW-1:0]] <= req.peer_addr;
    end
  end

endmodule

`default_nettype wire

// ===== design/lscb_checker.sv =====
// Port checker for the link self-cure block, bound to the top level.
// Depends on lscb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "link_self_cure_fsm_with_blocklist_assert.svh"

module lscb_checker (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input wire               done,
  input lscb_pkg::result_t result
);

  import lscb_pkg::*;

  logic accepted;
  logic add_clean;

  assign accepted  = start && !busy;
  assign add_clean = (result.detector_state == DET_INIT) && (result.retry_count == '0) &&
                     !result.blocked_hit;

  // An accepted request keeps the block busy until its result is shown.
  `LSCB_ASSERT_NEXT(a_accept_busy, accepted, busy && !done, "accepted request not busy")

  // The result appears only once the block has finished with its request.
  `LSCB_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")

  // Each request gives one result, so strobes never come back to back.
  `LSCB_ASSERT_NEXT(a_single_strobe, done, !done, "two results in consecutive cycles")

  // Adding a peer always ends the current check.
  `LSCB_ASSERT_NOW(a_add_resets, done && result.entry_added, add_clean, "add without check reset")

endmodule

bind link_self_cure_fsm_with_blocklist lscb_checker u_lscb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== dv/link_self_cure_fsm_with_blocklist_tb.sv =====
// Self-checking testbench for the link self-cure detector with peer blocklist.
// Depends on lscb_pkg and link_self_cure_fsm_with_blocklist; needs no other files.
// A queue-fed driver sends requests and register writes, and a monitor checks each result.
`timescale 1ns / 1ps

module link_self_cure_fsm_with_blocklist_tb;
  import lscb_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CFG_SETTLE  = 4;
  localparam int DRAIN_WAIT  = 30;
  localparam int STALL_LIMIT = 5000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    bit                    is_cfg;
    in_item_t              req;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    int unsigned           idle_pct;
  } stim_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  link_self_cure_fsm_with_blocklist #(
    .BLOCKLIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the detector, the blocklist and the registers.
  logic [DET_W-1:0]   det_q;
  logic [RETRY_W-1:0] retries_q;
  logic [ADDR_W-1:0]  assoc_q;
  logic [ADDR_W-1:0]  suspect_q;
  logic [ADDR_W-1:0]  blocked_peers [LIST_DEPTH];
  int unsigned        blocked_n;
  logic               feat_en_q;
  logic [RETRY_W-1:0] retry_limit_q;

  stim_t             pending [$];
  result_t           outcome_q [$];
  logic [ADDR_W-1:0] peers [$];
  int unsigned       gen_idle;
  int unsigned       gen_limit;
  int unsigned       reqs_taken = 0;
  int unsigned       results_seen = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       mismatches = 0;
  int unsigned       stall_cycles = 0;

  function automatic void restart_check();
    det_q     = DET_INIT;
    retries_q = '0;
    assoc_q   = '0;
    suspect_q = '0;
  endfunction

  function automatic void bump_retries();
    if (retries_q != RETRY_MAX) retries_q = retries_q + 1'b1;
  endfunction

  function automatic bit listed(logic [ADDR_W-1:0] peer);
    for (int i = 0; i < blocked_n && i < LIST_DEPTH; i++) begin
      if (blocked_peers[i] == peer) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit add_blocked(logic [ADDR_W-1:0] peer);
    // A full list is emptied before it takes the new peer.
    if (blocked_n >= LIST_DEPTH) blocked_n = 0;
    if (listed(peer)) return 1'b0;
    blocked_peers[blocked_n] = peer;
    blocked_n++;
    return 1'b1;
  endfunction

  function automatic bit link_event(in_item_t req);
    bit          added;
    bit          suspect_hit;
    bit          watched;
    logic [ADDR_W-1:0] peer;
    added   = 1'b0;
    peer    = req.peer_addr;
    watched = req.band_is_2g && req.peer_is_special_ap;
    if (peer != assoc_q) restart_check();
    suspect_hit = (suspect_q == peer);
    case (det_q)
      DET_INIT: begin
        if (req.command == CMD_ASSOC) begin
          if (req.protocol_class == PROTO_HT) begin
            assoc_q   = peer;
            det_q     = DET_ASSOC;
            retries_q = '0;
            if (watched) suspect_q = peer;
          end else begin
            restart_check();
          end
        end
      end
      DET_ASSOC: begin
        if (req.command == CMD_DHCP_TX) begin
          bump_retries();
          det_q = DET_HT_DHCP;
        end else if (req.command == CMD_EAPOL_RX) begin
          if (suspect_hit) suspect_q = '0;
        end else if (req.command == CMD_ASSOC) begin
          if (suspect_hit) det_q = DET_LEGACY_ASSOC;
        end
      end
      DET_HT_DHCP: begin
        if (req.command == CMD_DHCP_TX) begin
          bump_retries();
          if (retries_q > retry_limit_q) begin
            det_q     = DET_CLOSE_HT;
            suspect_q = peer;
          end
        end else if (req.command == CMD_DHCP_RX) begin
          restart_check();
        end
      end
      DET_CLOSE_HT: begin
        if (req.command == CMD_ASSOC) begin
          if (req.protocol_class == PROTO_LEGACY && suspect_hit) begin
            det_q     = DET_LEGACY_ASSOC;
            retries_q = '0;
          end else begin
            restart_check();
          end
        end else if (req.command == CMD_DHCP_RX) begin
          restart_check();
        end
      end
      DET_LEGACY_ASSOC: begin
        if (req.command == CMD_DHCP_TX) begin
          det_q = DET_LEGACY_DHCP;
          bump_retries();
        end else if (req.command == CMD_EAPOL_RX) begin
          if (watched && suspect_hit) begin
            added = add_blocked(peer);
            restart_check();
          end
        end else if (req.command == CMD_ASSOC) begin
          if (suspect_hit) restart_check();
        end
      end
      DET_LEGACY_DHCP: begin
        if (req.command == CMD_DHCP_TX) begin
          bump_retries();
          if (retries_q > retry_limit_q) restart_check();
        end else if (req.command == CMD_DHCP_RX) begin
          if (suspect_hit) begin
            added = add_blocked(peer);
            restart_check();
          end
        end
      end
      default: begin
      end
    endcase
    return added;
  endfunction

  function automatic bit peer_blocked(in_item_t req);
    if (!feat_en_q) return 1'b0;
    if (det_q == DET_CLOSE_HT && suspect_q == req.peer_addr) return 1'b1;
    if (req.peer_is_special_ap && suspect_q == req.peer_addr) return 1'b1;
    return listed(req.peer_addr);
  endfunction

  function automatic result_t cure_outcome(in_item_t req);
    result_t r;
    r = '0;
    if (req.command <= CMD_EAPOL_RX) begin
      if (req.sta_is_legacy && feat_en_q) r.entry_added = link_event(req);
    end else if (req.command == CMD_LOOKUP) begin
      r.blocked_hit = peer_blocked(req);
    end else if (req.command == CMD_CLEAR_ALL) begin
      restart_check();
      blocked_n = 0;
    end
    r.detector_state  = det_q;
    r.retry_count     = retries_q;
    r.blocklist_count = BCNT_W'(blocked_n);
    return r;
  endfunction

  // Stimulus building.
  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_peer();
    return peers[$urandom_range(peers.size() - 1)];
  endfunction

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] peer,
                          logic [PROTO_W-1:0] proto, logic b2g, logic sp,
                          logic legacy = 1'b1);
    stim_t s;
    s.is_cfg                 = 1'b0;
    s.req.command            = cmd;
    s.req.peer_addr          = peer;
    s.req.sta_is_legacy      = legacy;
    s.req.protocol_class     = proto;
    s.req.band_is_2g         = b2g;
    s.req.peer_is_special_ap = sp;
    s.reg_idx                = '0;
    s.reg_val                = '0;
    s.idle_pct               = gen_idle;
    pending.push_back(s);
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_t s;
    s.is_cfg   = 1'b1;
    s.req      = '0;
    s.reg_idx  = idx;
    s.reg_val  = val;
    s.idle_pct = 0;
    pending.push_back(s);
    if (idx == REG_RETRY_LIMIT) gen_limit = 32'(val);
  endtask

  // Link event with an occasional corrupted field to break the sequence.
  task automatic push_ev(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] peer,
                         logic [PROTO_W-1:0] proto, logic b2g, logic sp);
    logic        legacy;
    int unsigned roll;
    legacy = 1'b1;
    roll   = $urandom_range(99);
    if (roll < 2) legacy = 1'b0;
    else if (roll < 4) peer = pick_peer();
    else if (roll < 6) proto = PROTO_W'($urandom_range(3));
    else if (roll < 8) cmd = CMD_W'($urandom_range(7));
    push_req(cmd, peer, proto, b2g, sp, legacy);
  endtask

  task automatic push_lookup(logic [ADDR_W-1:0] peer);
    push_req(CMD_LOOKUP, peer, PROTO_W'($urandom_range(3)), 1'($urandom_range(1)),
             1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // One attempt at the fail-in-HT, recover-in-legacy pattern for a single peer.
  task automatic push_episode();
    logic [ADDR_W-1:0] p;
    logic              b2g;
    logic              sp;
    int unsigned       n_tx;
    if ($urandom_range(99) < 35) begin
      p = rand_addr();
      peers.push_back(p);
    end else begin
      p = pick_peer();
    end
    b2g = ($urandom_range(99) < 85);
    sp  = ($urandom_range(99) < 85);
    push_ev(CMD_ASSOC, p, PROTO_HT, b2g, sp);
    if ($urandom_range(3) == 0) begin
      // A watched peer that reassociates goes straight to legacy.
      push_ev(CMD_ASSOC, p, PROTO_HT, b2g, sp);
    end else begin
      n_tx = (gen_limit < 1) ? 2 : gen_limit + 1;
      n_tx = n_tx + $urandom_range(1);
      if ($urandom_range(99) < 15) n_tx = $urandom_range(1, n_tx);
      repeat (n_tx) push_ev(CMD_DHCP_TX, p, PROTO_HT, b2g, sp);
      if ($urandom_range(3) == 0) push_lookup(p);
      push_ev(CMD_ASSOC, p, ($urandom_range(9) == 0) ? PROTO_HT : PROTO_LEGACY, b2g, sp);
    end
    if ($urandom_range(1)) begin
      push_ev(CMD_EAPOL_RX, p, PROTO_LEGACY, b2g, sp);
    end else begin
      repeat ($urandom_range(1, 2)) push_ev(CMD_DHCP_TX, p, PROTO_LEGACY, b2g, sp);
      push_ev(CMD_DHCP_RX, p, PROTO_LEGACY, b2g, sp);
    end
    if ($urandom_range(99) < 40) push_lookup(pick_peer());
  endtask

  task automatic fill_random(int unsigned n);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = pending.size() + n;
    while (pending.size() < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 1) begin
        push_req(CMD_CLEAR_ALL, pick_peer(), PROTO_W'($urandom_range(3)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (roll < 15) begin
        push_req(CMD_W'($urandom_range(7)), $urandom_range(1) ? pick_peer() : rand_addr(),
                 PROTO_W'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      end else begin
        push_episode();
      end
    end
  endtask

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("result %0d %s: expected %0h, got %0h", results_seen, fname, want, got);
    end
  endtask

  // Driver: takes requests and register writes off the pending queue in order.
  always @(posedge clk) begin
    logic start_nx;
    logic cfg_nx;
    if (rst) begin
      start         <= 1'b0;
      cfg_valid     <= 1'b0;
      feat_en_q     = 1'b1;
      retry_limit_q = RETRY_LIMIT_RESET;
      restart_check();
      blocked_n     = 0;
      reqs_taken    = 0;
      quiet_cycles  = 0;
    end else begin
      start_nx = start;
      cfg_nx   = cfg_valid;
      if (start && !busy) begin
        outcome_q.push_back(cure_outcome(item));
        reqs_taken++;
        start_nx = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FEATURE_ENABLE: feat_en_q = cfg_data[0];
          REG_RETRY_LIMIT:    retry_limit_q = cfg_data;
          default: begin
          end
        endcase
        cfg_nx = 1'b0;
      end
      if (reqs_taken == results_seen && !busy && !start) quiet_cycles++;
      else quiet_cycles = 0;
      if (!start_nx && !cfg_nx && pending.size() != 0) begin
        if (pending[0].is_cfg) begin
          // Registers change only once every request has produced its result.
          if (quiet_cycles >= CFG_SETTLE) begin
            cfg_index <= pending[0].reg_idx;
            cfg_data  <= pending[0].reg_val;
            cfg_nx    = 1'b1;
            void'(pending.pop_front());
          end
        end else if ($urandom_range(99) >= pending[0].idle_pct) begin
          item     <= pending[0].req;
          start_nx = 1'b1;
          void'(pending.pop_front());
        end
      end
      start     <= start_nx;
      cfg_valid <= cfg_nx;
    end
  end

  // Monitor: every done strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (done) begin
      results_seen <= results_seen + 1;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d arrived with no request outstanding: %p", results_seen, result);
      end else begin
        want = outcome_q.pop_front();
        check_field("blocked_hit", want.blocked_hit, result.blocked_hit);
        check_field("entry_added", want.entry_added, result.entry_added);
        check_field("detector_state", want.detector_state, result.detector_state);
        check_field("retry_count", want.retry_count, result.retry_count);
        check_field("blocklist_count", want.blocklist_count, result.blocklist_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("link_self_cure_fsm_with_blocklist: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] pb;
    pa        = {ADDR_W{1'b1}};
    pb        = 48'h5A5A_C3C3_0F0F;
    gen_limit = RETRY_LIMIT_RESET;
    gen_idle  = 0;
    peers.push_back('0);
    peers.push_back(pa);
    peers.push_back(pb);
    repeat (5) peers.push_back(rand_addr());

    // Directed part under reset register values.
    push_req(CMD_CLEAR_ALL, '0, PROTO_LEGACY, 1'b0, 1'b0);
    push_req(CMD_LOOKUP, '0, PROTO_LEGACY, 1'b0, 1'b1);
    push_req(CMD_ASSOC, pa, PROTO_HT, 1'b1, 1'b1);
    push_req(CMD_ASSOC, pa, PROTO_HT, 1'b1, 1'b1);
    push_req(CMD_EAPOL_RX, pa, PROTO_LEGACY, 1'b1, 1'b1);
    push_req(CMD_LOOKUP, pa, PROTO_HT, 1'b0, 1'b0);
    push_req(CMD_ASSOC, pb, PROTO_HT, 1'b1, 1'b0);
    repeat (3) push_req(CMD_DHCP_TX, pb, PROTO_HT, 1'b1, 1'b0);
    push_req(CMD_LOOKUP, pb, PROTO_HT, 1'b0, 1'b0);
    push_req(CMD_ASSOC, pb, PROTO_LEGACY, 1'b1, 1'b0);
    push_req(CMD_DHCP_TX, pb, PROTO_LEGACY, 1'b1, 1'b0);
    push_req(CMD_DHCP_RX, pb, PROTO_LEGACY, 1'b1, 1'b0);
    // The same peer recovering again must not take a second entry.
    push_req(CMD_ASSOC, pa, PROTO_HT, 1'b1, 1'b1);
    push_req(CMD_ASSOC, pa, PROTO_HT, 1'b1, 1'b1);
    push_req(CMD_EAPOL_RX, pa, PROTO_LEGACY, 1'b1, 1'b1);
    push_req(CMD_ASSOC, pb, 2'd2, 1'b1, 1'b1);
    push_req(CMD_ASSOC, pb, 2'd3, 1'b1, 1'b1);
    push_req(CMD_ASSOC, pa, PROTO_HT, 1'b1, 1'b1, 1'b0);
    push_req(3'd6, pa, PROTO_HT, 1'b1, 1'b1);
    push_req(3'd7, pb, 2'd3, 1'b0, 1'b0);
    push_req(CMD_ASSOC, '0, PROTO_HT, 1'b1, 1'b1);
    push_req(CMD_DHCP_RX, pb, PROTO_HT, 1'b1, 1'b1);
    push_req(CMD_LOOKUP, '0, PROTO_HT, 1'b1, 1'b0);

    push_cfg(REG_RETRY_LIMIT, 4'd0);
    fill_random(90);
    push_cfg(REG_RETRY_LIMIT, 4'd15);
    gen_idle = 67;
    fill_random(90);
    push_cfg(REG_FEATURE_ENABLE, 4'd0);
    gen_idle = 35;
    fill_random(40);
    push_cfg(REG_FEATURE_ENABLE, 4'd1);
    push_cfg(REG_RETRY_LIMIT, 4'd1);
    gen_idle = 0;
    fill_random(100);
    push_cfg(REG_RETRY_LIMIT, CFG_DATA_W'($urandom_range(3, 14)));
    gen_idle = 67;
    fill_random(100);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending.size() != 0 || start || cfg_valid || reqs_taken != results_seen)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (outcome_q.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", outcome_q.size());
    end

    if (mismatches == 0) begin
      $display("link_self_cure_fsm_with_blocklist: match");
    end else begin
      $display("link_self_cure_fsm_with_blocklist: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lscb_pkg.sv
design/link_self_cure_fsm_with_blocklist.sv
design/lscb_checker.sv
dv/link_self_cure_fsm_with_blocklist_tb.sv
